// ===== rtl/three_phase_dds_generator_assert.svh =====
// Assertion macros shared by the DDS generator RTL.
`ifndef THREE_PHASE_DDS_GENERATOR_ASSERT_SVH
`define THREE_PHASE_DDS_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TPDDS_ASSERT_IMP(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TPDDS_ASSERT_NXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tpdds_pkg.sv =====
package tpdds_pkg;

  // Accumulator and offset register widths
  localparam int ACC_W    = 32;
  localparam int OFFSET_W = 12;

  // APB register map (byte address = 4 * index)
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_OFFSET_A = 2'd0;
  localparam logic [1:0] REG_OFFSET_B = 2'd1;
  localparam logic [1:0] REG_OFFSET_C = 2'd2;

  // Offset reset values, 1/4096 turn units
  localparam logic [OFFSET_W-1:0] OFFSET_A_RST = 12'd0;
  localparam logic [OFFSET_W-1:0] OFFSET_B_RST = 12'd1365;
  localparam logic [OFFSET_W-1:0] OFFSET_C_RST = 12'd2730;

  typedef struct packed {
    logic [OFFSET_W-1:0] a;
    logic [OFFSET_W-1:0] b;
    logic [OFFSET_W-1:0] c;
  } tpdds_offsets_t;

  // Q30 constants for the cosine table build
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_Q30    = 64'd1 << 29;

  // Taylor divisors (2n-1)(2n) for n = 1..10
  localparam logic [63:0] TAYLOR_DIV [1:10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
    64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

  // Quarter-wave entry: round(S * cos(pi/2 * idx / 2^qb)), S = 2^(sbits-1)-1.
  // Evaluated at elaboration only.
  function automatic logic [31:0] cos_entry(input int unsigned idx,
                                            input int unsigned qb,
                                            input int unsigned sbits);
    logic [63:0]    x;
    logic [63:0]    x2;
    logic [63:0]    term;
    logic [63:0]    c;
    logic [63:0]    full;
    logic [63:0]    prod;
    longint         sum;
    x    = (PI_HALF_Q30 * 64'(idx)) >> qb;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    sum  = longint'(ONE_Q30);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if ((n % 2) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
    c    = 64'(sum);
    full = (64'd1 << (sbits - 1)) - 64'd1;
    prod = (c * full + HALF_Q30) >> 30;
    return prod[31:0];
  endfunction

endpackage

// ===== rtl/tpdds_step_if.sv =====
// Phase step channel
interface tpdds_step_if;
  logic        valid;
  logic        ready;
  logic [31:0] phase_step;

  modport source (output valid, output phase_step, input ready);
  modport sink   (input valid, input phase_step, output ready);
endinterface

// ===== rtl/tpdds_wave_if.sv =====
// Three-phase sample channel
interface tpdds_wave_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] wave_a;
  logic signed [SAMPLE_BITS-1:0] wave_b;
  logic signed [SAMPLE_BITS-1:0] wave_c;

  modport source (output valid, output wave_a, output wave_b, output wave_c, input ready);
  modport sink   (input valid, input wave_a, input wave_b, input wave_c, output ready);
endinterface

// ===== rtl/tpdds_rom.sv =====
// Quarter-wave cosine ROM, registered read.
module tpdds_rom #(
  parameter int QB          = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [QB-1:0]          rd_addr,
  output logic [SAMPLE_BITS-2:0] rd_data
);
  import tpdds_pkg::*;

  localparam int DEPTH = 1 << QB;
  localparam int MAG_W = SAMPLE_BITS - 1;

  logic [MAG_W-1:0] rom [DEPTH];

  // Contents fixed at elaboration
  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    localparam logic [31:0] ENTRY = cos_entry(g, QB, SAMPLE_BITS);
    assign rom[g] = ENTRY[MAG_W-1:0];
  end

  // Read port; data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= rom[rd_addr];
  end

endmodule

// ===== rtl/tpdds_lane.sv =====
// One output phase: offset add, quadrant fold, table read, sign restore.
module tpdds_lane #(
  parameter int QB          = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [QB+1:0]                 phase,
  input  logic [QB+1:0]                 offset,
  output logic signed [SAMPLE_BITS-1:0] sample
);
  import tpdds_pkg::*;

  localparam int P     = QB + 2;
  localparam int MAG_W = SAMPLE_BITS - 1;

  typedef struct packed {
    logic neg;
    logic zero;
  } fold_t;

  logic [P-1:0]                  lane_phase;
  logic [1:0]                    quad;
  logic [QB-1:0]                 low;
  logic [QB-1:0]                 low_mirror;
  logic [QB-1:0]                 addr;
  logic [MAG_W-1:0]              mag;
  logic signed [SAMPLE_BITS-1:0] mag_s;
  fold_t                         fold_next;
  fold_t                         fold;

  // Phase plus offset wraps mod 2^P
  assign lane_phase = phase + offset;
  assign quad       = lane_phase[P-1 -: 2];
  assign low        = lane_phase[QB-1:0];
  assign low_mirror = '0 - low;

  // Odd quadrants read mirrored; quadrants 1 and 2 are negative
  assign addr           = quad[0] ? low_mirror : low;
  assign fold_next.neg  = quad[1] ^ quad[0];
  assign fold_next.zero = quad[0] && (low == '0);

  // Fold flags travel alongside the table read
  always_ff @(posedge clk) begin
    if (rd_en) fold <= fold_next;
  end

  tpdds_rom #(
    .QB          (QB),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (addr),
    .rd_data (mag)
  );

  assign mag_s = {1'b0, mag};

  // Sign restore
  always_comb begin
    priority if (fold.zero) sample = '0;
    else if (fold.neg)      sample = -mag_s;
    else                    sample = mag_s;
  end

endmodule

// ===== rtl/tpdds_regs.sv =====
// APB register file for the three phase offsets.
module tpdds_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tpdds_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tpdds_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tpdds_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  output tpdds_pkg::tpdds_offsets_t        offsets
);
  import tpdds_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  // Register writes; unmapped index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      offsets.a <= OFFSET_A_RST;
      offsets.b <= OFFSET_B_RST;
      offsets.c <= OFFSET_C_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OFFSET_A: offsets.a <= pwdata[OFFSET_W-1:0];
        REG_OFFSET_B: offsets.b <= pwdata[OFFSET_W-1:0];
        REG_OFFSET_C: offsets.c <= pwdata[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_OFFSET_A: prdata = APB_DATA_W'(offsets.a);
      REG_OFFSET_B: prdata = APB_DATA_W'(offsets.b);
      REG_OFFSET_C: prdata = APB_DATA_W'(offsets.c);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== rtl/three_phase_dds_generator.sv =====
// Channel  Dir  Beat contents                     Handshake
// step     in   phase_step (32b unsigned)         valid/ready
// wave     out  wave_a, wave_b, wave_c (signed)   valid/ready
// apb      in   offset_phase_a/b/c at 0x0/0x4/0x8 psel/penable, pready tied high
//
// One beat per clock sustained while wave is ready; a taken beat passes the registered
// read of the three quarter-wave ROMs and then the output register before it appears
// on wave.
// Reset (rst, synchronous) clears the accumulator and pipeline and restores offsets.
// A stalled output holds its beat; step is stalled only while both the ROM stage
// and the output register are full and wave is not ready.
`include "three_phase_dds_generator_assert.svh"

module three_phase_dds_generator #(
  parameter int TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tpdds_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tpdds_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tpdds_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  tpdds_step_if.sink                       step,
  tpdds_wave_if.source                     wave
);
  import tpdds_pkg::*;

  // Quarter table holds the largest power of two not above TABLE_DEPTH
  localparam int QB  = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int P   = QB + 2;
  localparam int SHL = (P >= OFFSET_W) ? P - OFFSET_W : 0;
  localparam int SHR = (P < OFFSET_W) ? OFFSET_W - P : 0;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  tpdds_offsets_t                offsets;
  logic [ACC_W-1:0]              acc;
  logic [ACC_W-1:0]              acc_next;
  logic [P-1:0]                  phase;
  logic [P-1:0]                  off_a;
  logic [P-1:0]                  off_b;
  logic [P-1:0]                  off_c;
  logic                          in_fire;
  logic                          out_adv;
  logic                          s1_valid;
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] samp_a;
  logic signed [SAMPLE_BITS-1:0] samp_b;
  logic signed [SAMPLE_BITS-1:0] samp_c;
  logic signed [SAMPLE_BITS-1:0] wave_a_q;
  logic signed [SAMPLE_BITS-1:0] wave_b_q;
  logic signed [SAMPLE_BITS-1:0] wave_c_q;

  // Offsets in 1/4096 turns rescaled to P phase bits
  function automatic logic [P-1:0] scale_off(input logic [OFFSET_W-1:0] off);
    logic [ACC_W-1:0] wide;
    wide = (ACC_W'(off) << SHL) >> SHR;
    return wide[P-1:0];
  endfunction

  tpdds_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .offsets (offsets)
  );

  // Handshake: ROM stage takes a beat when empty or when it empties into the output register
  assign out_adv    = !out_valid || wave.ready;
  assign step.ready = !s1_valid || out_adv;
  assign in_fire    = step.valid && step.ready;

  // Phase accumulator
  assign acc_next = acc + step.phase_step;
  assign phase    = acc_next[ACC_W-1 -: P];

  always_ff @(posedge clk) begin
    if (rst) acc <= '0;
    else if (in_fire) acc <= acc_next;
  end

  assign off_a = scale_off(offsets.a);
  assign off_b = scale_off(offsets.b);
  assign off_c = scale_off(offsets.c);

  tpdds_lane #(.QB(QB), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_a (
    .clk (clk), .rd_en (in_fire), .phase (phase), .offset (off_a), .sample (samp_a)
  );
  tpdds_lane #(.QB(QB), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_b (
    .clk (clk), .rd_en (in_fire), .phase (phase), .offset (off_b), .sample (samp_b)
  );
  tpdds_lane #(.QB(QB), .SAMPLE_BITS(SAMPLE_BITS)) u_lane_c (
    .clk (clk), .rd_en (in_fire), .phase (phase), .offset (off_c), .sample (samp_c)
  );

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire)      s1_valid <= 1'b1;
      else if (out_adv) s1_valid <= 1'b0;
      if (out_adv) out_valid <= s1_valid;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (s1_valid && out_adv) begin
      wave_a_q <= samp_a;
      wave_b_q <= samp_b;
      wave_c_q <= samp_c;
    end
  end

  assign wave.valid  = out_valid;
  assign wave.wave_a = wave_a_q;
  assign wave.wave_b = wave_b_q;
  assign wave.wave_c = wave_c_q;

  // Checks
  `TPDDS_ASSERT_NXT(a_acc_adv, clk, rst, in_fire, acc == $past(acc_next), "accumulator missed a step")
  `TPDDS_ASSERT_NXT(a_acc_hold, clk, rst, !in_fire, $stable(acc), "accumulator moved without a beat")
  `TPDDS_ASSERT_NXT(a_s1_move, clk, rst, s1_valid && out_adv, out_valid, "ROM stage beat lost")
  `TPDDS_ASSERT_IMP(a_range, clk, rst, out_valid, (wave_a_q != SAMPLE_MIN) && (wave_b_q != SAMPLE_MIN) && (wave_c_q != SAMPLE_MIN), "sample outside full scale")

endmodule
